@@ design/rbsw_pkg.sv @@
// Shared types, constants and mask helpers for the raster band span writer.
`default_nettype none

package rbsw_pkg;

  localparam int DEF_BAND_ROWS = 64;
  localparam int DEF_MAX_WORDS = 256;

  localparam int FUNC_W    = 2;
  localparam int LINE_W    = 16;
  localparam int PIX_W     = 14;
  localparam int DATA_W    = 32;
  localparam int WIDX_W    = 8;
  localparam int WCOL_W    = 9;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 1;
  localparam int ROWK_W    = 11;
  localparam int DIV_SHIFT = 26;
  localparam int RECIP_W   = 27;

  localparam logic [PIX_W-1:0] WIDTH_RESET = 14'd7040;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_FILL  = 2'd0,
    FUNC_CLEAR = 2'd1,
    FUNC_GLYPH = 2'd2,
    FUNC_READ  = 2'd3
  } func_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BASE_LINE  = 1'b0,
    CFG_LINE_WIDTH = 1'b1
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DIV,
    ST_ROW,
    ST_RD,
    ST_WR,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic idle;
    logic clr_wr;
    logic load;
    logic div_step;
    logic row_step;
    logic rd;
    logic wr;
    logic finish;
  } ctl_t;

  typedef struct packed {
    logic clear_last;
    logic rej;
    logic more;
    logic more_next;
    logic out_free;
  } sts_t;

  function automatic logic [DATA_W-1:0] left_edge_mask(input logic [4:0] p);
    logic [DATA_W-1:0] m;
    m = 32'hffffff00 | (32'h000000ff >> p[2:0]);
    return m << {p[4:3], 3'b000};
  endfunction

endpackage

`default_nettype wire

@@ design/rbsw_cmd_if.sv @@
// Command channel: one drawing or read-and-clear operation per beat.
`default_nettype none

interface rbsw_cmd_if;
  import rbsw_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [FUNC_W-1:0]        func;
  logic [LINE_W-1:0]        line;
  logic signed [PIX_W-1:0]  from_x;
  logic signed [PIX_W-1:0]  to_x;
  logic [DATA_W-1:0]        pattern;
  logic [WIDX_W-1:0]        word_index;

  modport source(output valid, func, line, from_x, to_x, pattern, word_index, input ready);
  modport sink(input valid, func, line, from_x, to_x, pattern, word_index, output ready);
endinterface

`default_nettype wire

@@ design/rbsw_rsp_if.sv @@
// Response channel: read data and reject flag, one beat per command.
`default_nettype none

interface rbsw_rsp_if;
  import rbsw_pkg::*;

  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] read_data;
  logic              rejected;

  modport source(output valid, read_data, rejected, input ready);
  modport sink(input valid, read_data, rejected, output ready);
endinterface

`default_nettype wire

@@ design/rbsw_ctrl.sv @@
// Controller: sequences memory clear, row mapping and per-word read-modify-write.
`default_nettype none

module rbsw_ctrl (
  input  wire              clk,
  input  wire              rst,
  input  wire              cmd_valid,
  input  rbsw_pkg::sts_t   sts,
  output rbsw_pkg::ctl_t   ctl
);
  import rbsw_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: begin
        if (sts.clear_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (cmd_valid) state_next = ST_DIV;
      end
      ST_DIV: begin
        state_next = ST_ROW;
      end
      ST_ROW: begin
        if (!sts.rej && sts.more) state_next = ST_RD;
        else state_next = ST_DONE;
      end
      ST_RD: begin
        state_next = ST_WR;
      end
      ST_WR: begin
        if (sts.more_next) state_next = ST_RD;
        else state_next = ST_DONE;
      end
      ST_DONE: begin
        if (sts.out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_CLEAR;
    endcase
  end

  always_comb begin
    ctl = '0;
    unique case (state)
      ST_CLEAR: ctl.clr_wr = 1'b1;
      ST_IDLE: begin
        ctl.idle = 1'b1;
        ctl.load = cmd_valid;
      end
      ST_DIV:  ctl.div_step = 1'b1;
      ST_ROW:  ctl.row_step = 1'b1;
      ST_RD:   ctl.rd = 1'b1;
      ST_WR:   ctl.wr = 1'b1;
      ST_DONE: ctl.finish = sts.out_free;
      default: ctl = '0;
    endcase
  end

endmodule

`default_nettype wire

@@ design/rbsw_dp.sv @@
// Datapath: config registers, row mapping, raster memory, word masks, result register.
`default_nettype none

module rbsw_dp #(
  parameter int BAND_ROWS         = rbsw_pkg::DEF_BAND_ROWS,
  parameter int MAX_WORDS_PER_ROW = rbsw_pkg::DEF_MAX_WORDS
) (
  input  wire                                clk,
  input  wire                                rst,
  input  wire                                cfg_wr_en,
  input  wire [rbsw_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire [rbsw_pkg::CFG_W-1:0]          cfg_wdata,
  input  rbsw_pkg::ctl_t                     ctl,
  output rbsw_pkg::sts_t                     sts,
  rbsw_cmd_if.sink                           cmd,
  rbsw_rsp_if.source                         rsp
);
  import rbsw_pkg::*;

  localparam int ROW_W  = (BAND_ROWS > 1) ? $clog2(BAND_ROWS) : 1;
  localparam int WORD_W = (MAX_WORDS_PER_ROW > 1) ? $clog2(MAX_WORDS_PER_ROW) : 1;
  localparam int AW     = ROW_W + WORD_W;
  localparam int DEPTH  = 1 << AW;
  localparam int PROD_W = LINE_W + RECIP_W;
  localparam int QM_W   = LINE_W + ROWK_W;
  localparam logic [RECIP_W-1:0] RECIP =
    RECIP_W'(((64'd1 << DIV_SHIFT) + 64'(BAND_ROWS) - 64'd1) / 64'(BAND_ROWS));
  localparam logic [ROWK_W-1:0] ROWS_K      = ROWK_W'(BAND_ROWS);
  localparam logic [WCOL_W-1:0] MAX_WORDS_K = WCOL_W'(MAX_WORDS_PER_ROW);

  logic [LINE_W-1:0]        base_line;
  logic [PIX_W-1:0]         line_width;

  func_t                    func_r;
  logic [LINE_W-1:0]        line_r;
  logic signed [PIX_W-1:0]  from_r;
  logic signed [PIX_W-1:0]  to_r;
  logic [DATA_W-1:0]        pat_r;
  logic [WIDX_W-1:0]        widx_r;

  logic [WCOL_W-1:0]        wpr;
  logic [PIX_W-1:0]         width_pix;
  logic signed [PIX_W:0]    width_s;
  logic signed [PIX_W:0]    from_s;
  logic signed [PIX_W:0]    end_excl;
  logic [PIX_W-1:0]         glyph_q;
  logic                     below;
  logic                     rej;
  logic [WCOL_W-1:0]        ws;
  logic [WCOL_W-1:0]        we;
  logic [WCOL_W-1:0]        w_inc;

  logic [LINE_W-1:0]        diff;
  logic [PROD_W-1:0]        prod;
  logic [LINE_W-1:0]        quot;
  logic [QM_W-1:0]          qm;
  logic [LINE_W-1:0]        rem;
  logic [ROW_W-1:0]         row;
  logic [WCOL_W-1:0]        w;

  logic [DATA_W-1:0]        mem [DEPTH];
  logic [DATA_W-1:0]        rdata;
  logic [AW-1:0]            clr_cnt;
  logic [AW-1:0]            word_addr;
  logic                     mem_we;
  logic [AW-1:0]            mem_waddr;
  logic [DATA_W-1:0]        mem_wdata;

  logic [DATA_W-1:0]        fmask;
  logic [DATA_W-1:0]        tmask;
  logic [DATA_W-1:0]        span_mask;
  logic [DATA_W-1:0]        glyph_lo;
  logic [DATA_W-1:0]        glyph_hi;
  logic [DATA_W-1:0]        new_word;

  logic [DATA_W-1:0]        data_work;
  logic                     rsp_valid;
  logic [DATA_W-1:0]        read_data;
  logic                     rejected;

  always_ff @(posedge clk) begin
    if (rst) begin
      base_line  <= '0;
      line_width <= WIDTH_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_BASE_LINE:  base_line  <= cfg_wdata[LINE_W-1:0];
        CFG_LINE_WIDTH: line_width <= cfg_wdata[PIX_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      func_r <= func_t'(cmd.func);
      line_r <= cmd.line;
      from_r <= cmd.from_x;
      to_r   <= cmd.to_x;
      pat_r  <= cmd.pattern;
      widx_r <= cmd.word_index;
    end
  end

  assign cmd.ready = ctl.idle;

  always_comb begin
    wpr       = (line_width[PIX_W-1:5] > MAX_WORDS_K) ? MAX_WORDS_K : line_width[PIX_W-1:5];
    width_pix = {wpr, 5'b00000};
    width_s   = $signed({1'b0, width_pix});
    from_s    = $signed({from_r[PIX_W-1], from_r});
    end_excl  = $signed({to_r[PIX_W-1], to_r}) + 15'sd1;
    glyph_q   = $unsigned(from_r) + 14'd8;
    below     = line_r < base_line;
    rej       = below;
    ws        = $unsigned(from_r[PIX_W-1:5]);
    we        = $unsigned(end_excl[PIX_W-1:5]);
    unique case (func_r)
      FUNC_FILL, FUNC_CLEAR: begin
        if (from_r[PIX_W-1] || (end_excl > width_s) || (end_excl < from_s)) rej = 1'b1;
      end
      FUNC_GLYPH: begin
        if (from_r[PIX_W-1] || (from_s >= width_s)) rej = 1'b1;
        we = glyph_q[PIX_W-1:5];
      end
      FUNC_READ: begin
        if ({1'b0, widx_r} >= wpr) rej = 1'b1;
        ws = {1'b0, widx_r};
        we = {1'b0, widx_r};
      end
      default: rej = 1'b1;
    endcase
  end

  assign diff = line_r - base_line;
  assign prod = diff * RECIP;
  assign qm   = quot * ROWS_K;
  assign rem  = diff - qm[LINE_W-1:0];

  always_ff @(posedge clk) begin
    if (ctl.div_step) begin
      quot <= prod[DIV_SHIFT+LINE_W-1:DIV_SHIFT];
    end
    if (ctl.row_step) begin
      row <= rem[ROW_W-1:0];
    end
  end

  assign w_inc = w + 9'd1;

  always_ff @(posedge clk) begin
    if (ctl.div_step) begin
      w <= ws;
    end else if (ctl.wr) begin
      w <= w_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (ctl.clr_wr) begin
      clr_cnt <= clr_cnt + AW'(1);
    end
  end

  assign word_addr = {row, w[WORD_W-1:0]};
  assign mem_we    = ctl.clr_wr || ctl.wr;
  assign mem_waddr = ctl.clr_wr ? clr_cnt : word_addr;
  assign mem_wdata = ctl.clr_wr ? '0 : new_word;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (ctl.rd) begin
      rdata <= mem[word_addr];
    end
  end

  always_comb begin
    fmask     = left_edge_mask(from_r[4:0]);
    tmask     = ~left_edge_mask(end_excl[4:0]);
    span_mask = '1;
    if (w == ws) span_mask = span_mask & fmask;
    if (w == we) span_mask = span_mask & tmask;
    glyph_lo  = ((32'(pat_r[7:0]) >> from_r[2:0]) & 32'h000000ff) << {from_r[4:3], 3'b000};
    glyph_hi  = ((32'({pat_r[7:0], 8'h00}) >> from_r[2:0]) & 32'h000000ff)
                << {glyph_q[4:3], 3'b000};
    unique case (func_r)
      FUNC_FILL:  new_word = rdata | (pat_r & span_mask);
      FUNC_CLEAR: new_word = rdata & ~span_mask;
      FUNC_GLYPH: new_word = rdata | ((w == ws) ? glyph_lo : '0) | ((w == we) ? glyph_hi : '0);
      FUNC_READ:  new_word = '0;
      default:    new_word = rdata;
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      data_work <= '0;
    end else if (ctl.wr && (func_r == FUNC_READ)) begin
      data_work <= rdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (ctl.finish) begin
      rsp_valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.finish) begin
      read_data <= rej ? '0 : data_work;
      rejected  <= rej;
    end
  end

  assign rsp.valid     = rsp_valid;
  assign rsp.read_data = read_data;
  assign rsp.rejected  = rejected;

  assign sts.clear_last = &clr_cnt;
  assign sts.rej        = rej;
  assign sts.more       = (w <= we) && (w < wpr);
  assign sts.more_next  = (w < we) && (w_inc < wpr);
  assign sts.out_free   = !rsp_valid || rsp.ready;

endmodule

`default_nettype wire

@@ design/raster_band_span_writer.sv @@
// Top level: band raster memory with span fill, span clear, glyph and dump operations.
//
//   channel  dir  handshake     beat contents
//   cmd      in   valid/ready   func, line, from_x, to_x, pattern, word_index
//   rsp      out  valid/ready   read_data, rejected
//   cfg      in   cfg_wr_en     cfg_index, cfg_wdata
//
// A command runs row mapping and then one memory read and one write for each of the
// words it touches (on the single-port array); a rejected command skips the word
// steps. Row mapping uses a two-stage reciprocal multiply.
// After reset a clearing pass writes 2^(ROW_W+WORD_W) words (16384 by default)
// with cmd.ready low. A held result does not block the next accept; only the
// final step of the next command waits for the response register to drain.
`default_nettype none

module raster_band_span_writer #(
  parameter int BAND_ROWS         = rbsw_pkg::DEF_BAND_ROWS,
  parameter int MAX_WORDS_PER_ROW = rbsw_pkg::DEF_MAX_WORDS
) (
  input  wire                             clk,
  input  wire                             rst,
  input  wire                             cfg_wr_en,
  input  wire [rbsw_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire [rbsw_pkg::CFG_W-1:0]       cfg_wdata,
  rbsw_cmd_if.sink                        cmd,
  rbsw_rsp_if.source                      rsp
);
  import rbsw_pkg::*;

  ctl_t ctl;
  sts_t sts;

  rbsw_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd.valid),
    .sts       (sts),
    .ctl       (ctl)
  );

  rbsw_dp #(
    .BAND_ROWS         (BAND_ROWS),
    .MAX_WORDS_PER_ROW (MAX_WORDS_PER_ROW)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .ctl       (ctl),
    .sts       (sts),
    .cmd       (cmd),
    .rsp       (rsp)
  );

  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (cmd.valid && cmd.ready) |=> !cmd.ready)
    else $error("command accepted while another is in flight");

  a_reject_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.rejected) |-> (rsp.read_data == '0))
    else $error("rejected beat carries read data");

  a_clear_blocks: assert property (@(posedge clk)
    $fell(rst) |-> !cmd.ready)
    else $error("command accepted during memory clear");

endmodule

`default_nettype wire

@@ sim/raster_band_span_writer_test.sv @@
// Self-checking testbench for the raster band span writer, checked against a behavioral band image.
module raster_band_span_writer_test;
  import rbsw_pkg::*;

  localparam int ROWS         = DEF_BAND_ROWS;
  localparam int ROW_WORDS    = DEF_MAX_WORDS;
  localparam int CYCLE_LIMIT  = 2000000;
  localparam int DRAIN_CYCLES = 64;

  typedef struct packed {
    func_t             func;
    logic [LINE_W-1:0] line;
    logic [PIX_W-1:0]  from_x;
    logic [PIX_W-1:0]  to_x;
    logic [DATA_W-1:0] pattern;
    logic [WIDX_W-1:0] word_index;
  } draw_beat_t;

  typedef struct packed {
    logic [DATA_W-1:0] read_data;
    logic              rejected;
  } rsp_beat_t;

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 cfg_wr_en;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_wdata;

  rbsw_cmd_if cmd_ch();
  rbsw_rsp_if rsp_ch();

  raster_band_span_writer uut (
    .clk(clk),
    .rst(rst),
    .cfg_wr_en(cfg_wr_en),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .cmd(cmd_ch),
    .rsp(rsp_ch)
  );

  logic [DATA_W-1:0] band_image [0:ROWS*ROW_WORDS-1];
  logic [LINE_W-1:0] base_line_q;
  logic [PIX_W-1:0]  width_q;
  draw_beat_t        cmd_backlog[$];
  rsp_beat_t         expected_rsp[$];
  draw_beat_t        bus_beat;
  logic              quiet;
  int                mismatches;
  int                cycle_count = 0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic int row_word_count();
    int n;
    n = int'(width_q) / 32;
    return (n > ROW_WORDS) ? ROW_WORDS : n;
  endfunction

  // pixels at or right of p within its word; byte 0 leftmost, bit 7 leads each byte
  function automatic logic [DATA_W-1:0] pixels_from(input int p);
    logic [DATA_W-1:0] m;
    int k;
    m = '0;
    for (k = p % 32; k < 32; k++) m[(k / 8) * 8 + 7 - (k % 8)] = 1'b1;
    return m;
  endfunction

  function automatic rsp_beat_t predict_band_op(input draw_beat_t b);
    rsp_beat_t r;
    int wpr, usable, from, stop, first_w, last_w, w, row, hi_w;
    logic [DATA_W-1:0] m;
    logic [15:0] spread;
    r = '0;
    wpr = row_word_count();
    usable = wpr * 32;
    from = int'($signed(b.from_x));
    stop = int'($signed(b.to_x)) + 1;
    if (b.line < base_line_q) begin
      r.rejected = 1'b1;
    end else begin
      row = ((int'(b.line) - int'(base_line_q)) % ROWS) * ROW_WORDS;
      case (b.func)
        FUNC_FILL, FUNC_CLEAR: begin
          if (from < 0 || stop > usable || stop < from) begin
            r.rejected = 1'b1;
          end else begin
            first_w = from / 32;
            last_w = stop / 32;
            for (w = first_w; w <= last_w; w++) begin
              if (w < wpr) begin
                m = '1;
                if (w == first_w) m &= pixels_from(from);
                if (w == last_w) m &= ~pixels_from(stop);
                if (b.func == FUNC_CLEAR) band_image[row + w] &= ~m;
                else band_image[row + w] |= b.pattern & m;
              end
            end
          end
        end
        FUNC_GLYPH: begin
          if (from < 0 || from >= usable) begin
            r.rejected = 1'b1;
          end else begin
            spread = {b.pattern[7:0], 8'h00} >> (from % 8);
            hi_w = (from + 8) / 32;
            band_image[row + from / 32] |= {24'h0, spread[15:8]} << (8 * ((from % 32) / 8));
            if (hi_w < wpr)
              band_image[row + hi_w] |= {24'h0, spread[7:0]} << (8 * (((from + 8) % 32) / 8));
          end
        end
        default: begin
          if (int'(b.word_index) >= wpr) begin
            r.rejected = 1'b1;
          end else begin
            r.read_data = band_image[row + int'(b.word_index)];
            band_image[row + int'(b.word_index)] = '0;
          end
        end
      endcase
    end
    return r;
  endfunction

  function automatic draw_beat_t mk_beat(input func_t f, input int line, input int from,
                                         input int to, input logic [DATA_W-1:0] pat,
                                         input int widx);
    draw_beat_t b;
    b.func = f;
    b.line = LINE_W'(line);
    b.from_x = PIX_W'(from);
    b.to_x = PIX_W'(to);
    b.pattern = pat;
    b.word_index = WIDX_W'(widx);
    return b;
  endfunction

  function automatic draw_beat_t random_draw_beat();
    draw_beat_t b;
    int wpr, usable, from, to, span_len, pick;
    logic hot;
    wpr = row_word_count();
    usable = wpr * 32;
    b.pattern = ($urandom_range(0, 9) == 0) ? '1 : $urandom;
    pick = $urandom_range(0, 99);
    b.func = (pick < 35) ? FUNC_FILL : (pick < 50) ? FUNC_CLEAR :
             (pick < 70) ? FUNC_GLYPH : FUNC_READ;
    hot = ($urandom_range(0, 99) < 70);
    pick = $urandom_range(0, 99);
    if (pick < 5) b.line = base_line_q - 16'd1;
    else if (pick < 15) b.line = LINE_W'($urandom);
    else if (hot) b.line = base_line_q + LINE_W'($urandom_range(0, 7) + 64 * $urandom_range(0, 1));
    else b.line = base_line_q + LINE_W'($urandom_range(0, 127));
    if (wpr > 0 && $urandom_range(0, 99) < 85)
      b.word_index = WIDX_W'($urandom_range(0, (hot && wpr > 8) ? 7 : wpr - 1));
    else
      b.word_index = WIDX_W'($urandom);
    if (usable > 0 && $urandom_range(0, 99) < 88) begin
      from = $urandom_range(0, (hot && usable > 256) ? 255 : usable - 1);
      span_len = ($urandom_range(0, 19) == 0) ? $urandom_range(0, usable - from)
                                               : $urandom_range(0, 70);
      to = from + span_len - 1;
      if (to > usable - 1) to = usable - 1;
      b.from_x = PIX_W'(from);
      b.to_x = PIX_W'(to);
    end else begin
      b.from_x = PIX_W'($urandom);
      b.to_x = PIX_W'($urandom);
    end
    return b;
  endfunction

  task automatic write_reg(input cfg_idx_t idx, input logic [CFG_W-1:0] value);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    if (idx == CFG_BASE_LINE) base_line_q = value;
    else width_q = value[PIX_W-1:0];
  endtask

  // sample at the falling edge so the driver's updates have settled
  task automatic drain_backlog();
    while (cmd_backlog.size() != 0 || cmd_ch.valid || expected_rsp.size() != 0)
      @(negedge clk);
  endtask

  task automatic push_random(input int n);
    repeat (n) cmd_backlog.push_back(random_draw_beat());
  endtask

  always @(posedge clk) begin
    if (rst) begin
      cmd_ch.valid <= 1'b0;
    end else begin
      if (cmd_ch.valid && cmd_ch.ready) expected_rsp.push_back(predict_band_op(bus_beat));
      if (!cmd_ch.valid || cmd_ch.ready) begin
        if (cmd_backlog.size() != 0 && (quiet || $urandom_range(0, 99) >= 30)) begin
          bus_beat = cmd_backlog.pop_front();
          cmd_ch.valid <= 1'b1;
          cmd_ch.func <= bus_beat.func;
          cmd_ch.line <= bus_beat.line;
          cmd_ch.from_x <= bus_beat.from_x;
          cmd_ch.to_x <= bus_beat.to_x;
          cmd_ch.pattern <= bus_beat.pattern;
          cmd_ch.word_index <= bus_beat.word_index;
        end else begin
          cmd_ch.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    rsp_beat_t want;
    if (rst) begin
      rsp_ch.ready <= 1'b0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (expected_rsp.size() == 0) begin
          $display("%0t: unexpected beat: read_data=%h rejected=%b", $time,
                   rsp_ch.read_data, rsp_ch.rejected);
          mismatches++;
        end else begin
          want = expected_rsp.pop_front();
          if (rsp_ch.read_data !== want.read_data) begin
            $display("%0t: read_data expected %h actual %h", $time, want.read_data,
                     rsp_ch.read_data);
            mismatches++;
          end
          if (rsp_ch.rejected !== want.rejected) begin
            $display("%0t: rejected expected %b actual %b", $time, want.rejected,
                     rsp_ch.rejected);
            mismatches++;
          end
        end
      end
      rsp_ch.ready <= quiet || ($urandom_range(0, 99) >= 30);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    int i;
    rst = 1'b1;
    cfg_wr_en = 1'b0;
    cfg_index = CFG_BASE_LINE;
    cfg_wdata = '0;
    cmd_ch.valid = 1'b0;
    cmd_ch.func = FUNC_FILL;
    cmd_ch.line = '0;
    cmd_ch.from_x = '0;
    cmd_ch.to_x = '0;
    cmd_ch.pattern = '0;
    cmd_ch.word_index = '0;
    rsp_ch.ready = 1'b0;
    quiet = 1'b0;
    mismatches = 0;
    base_line_q = '0;
    width_q = WIDTH_RESET;
    for (i = 0; i < ROWS * ROW_WORDS; i++) band_image[i] = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    cmd_backlog.push_back(mk_beat(FUNC_FILL, 0, 0, 31, 32'hffffffff, 0));
    cmd_backlog.push_back(mk_beat(FUNC_READ, 0, 0, 0, 32'h0, 0));
    cmd_backlog.push_back(mk_beat(FUNC_FILL, 1, 3, 44, 32'ha5a5a5a5, 0));
    cmd_backlog.push_back(mk_beat(FUNC_READ, 1, 0, 0, 32'h0, 1));
    cmd_backlog.push_back(mk_beat(FUNC_FILL, 2, 0, 7039, 32'h12345678, 0));
    cmd_backlog.push_back(mk_beat(FUNC_CLEAR, 2, 100, 6000, 32'h0, 0));
    cmd_backlog.push_back(mk_beat(FUNC_READ, 2, 0, 0, 32'h0, 3));
    cmd_backlog.push_back(mk_beat(FUNC_READ, 66, 0, 0, 32'h0, 219));
    cmd_backlog.push_back(mk_beat(FUNC_CLEAR, 3, -1, 5, 32'h0, 0));
    cmd_backlog.push_back(mk_beat(FUNC_FILL, 3, 0, 7040, 32'hffffffff, 0));
    cmd_backlog.push_back(mk_beat(FUNC_FILL, 3, 10, 8, 32'hffffffff, 0));
    cmd_backlog.push_back(mk_beat(FUNC_FILL, 3, 10, 9, 32'h0, 0));
    cmd_backlog.push_back(mk_beat(FUNC_FILL, 3, -8192, 8191, 32'hffffffff, 0));
    cmd_backlog.push_back(mk_beat(FUNC_GLYPH, 4, 0, 0, 32'h000000ff, 0));
    cmd_backlog.push_back(mk_beat(FUNC_GLYPH, 4, 13, 0, 32'hffffffc3, 0));
    cmd_backlog.push_back(mk_beat(FUNC_GLYPH, 4, 29, 0, 32'h000000ff, 0));
    cmd_backlog.push_back(mk_beat(FUNC_READ, 4, 0, 0, 32'h0, 0));
    cmd_backlog.push_back(mk_beat(FUNC_GLYPH, 5, 7036, 0, 32'h000000ff, 0));
    cmd_backlog.push_back(mk_beat(FUNC_READ, 5, 0, 0, 32'h0, 219));
    cmd_backlog.push_back(mk_beat(FUNC_GLYPH, 5, 7040, 0, 32'h000000ff, 0));
    cmd_backlog.push_back(mk_beat(FUNC_GLYPH, 5, -8192, 0, 32'h000000ff, 0));
    cmd_backlog.push_back(mk_beat(FUNC_READ, 65535, 0, 0, 32'h0, 255));
    cmd_backlog.push_back(mk_beat(FUNC_READ, 65535, 0, 0, 32'h0, 219));
    cmd_backlog.push_back(mk_beat(FUNC_READ, 0, 0, 0, 32'h0, 0));
    drain_backlog();

    write_reg(CFG_BASE_LINE, 16'd100);
    write_reg(CFG_LINE_WIDTH, 16'd8192);
    cmd_backlog.push_back(mk_beat(FUNC_READ, 99, 0, 0, 32'h0, 0));
    cmd_backlog.push_back(mk_beat(FUNC_READ, 100, 0, 0, 32'h0, 0));
    push_random(120);
    drain_backlog();

    write_reg(CFG_BASE_LINE, 16'd0);
    write_reg(CFG_LINE_WIDTH, 16'd32);
    push_random(50);
    drain_backlog();

    write_reg(CFG_BASE_LINE, 16'hffff);
    write_reg(CFG_LINE_WIDTH, 16'd16);
    cmd_backlog.push_back(mk_beat(FUNC_FILL, 65535, 0, -1, 32'hffffffff, 0));
    push_random(20);
    drain_backlog();

    write_reg(CFG_BASE_LINE, 16'd7);
    write_reg(CFG_LINE_WIDTH, 16'd640);
    quiet = 1'b1;
    push_random(110);
    drain_backlog();
    quiet = 1'b0;

    write_reg(CFG_BASE_LINE, 16'd3000);
    write_reg(CFG_LINE_WIDTH, 16'h3fff);
    push_random(150);
    drain_backlog();

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && expected_rsp.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

@@ files.f @@
design/rbsw_pkg.sv
design/rbsw_cmd_if.sv
design/rbsw_rsp_if.sv
design/rbsw_ctrl.sv
design/rbsw_dp.sv
design/raster_band_span_writer.sv
sim/raster_band_span_writer_test.sv
